// ===== rtl/core/cfpr_pkg.sv =====
// Shared types and constants for the framed packet receiver.
// No dependencies; imported by every module in rtl/core.
package cfpr_pkg;

    // Frame format
    localparam logic [7:0]  START_BYTE  = 8'hAA;
    localparam logic [7:0]  ABORT_CMD   = 8'h55;
    localparam int          MAX_PAYLOAD = 64;

    // CRC16-Modbus, reflected form
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam int          CRC_STEPS   = 8;
    localparam int          CRC_CNT_W   = $clog2(CRC_STEPS + 1);

    // Payload store and field widths
    localparam int          STORE_DEPTH = 64;
    localparam int          ADDR_W      = $clog2(STORE_DEPTH);
    localparam int          LEN_W       = 7;
    localparam int          TDATA_W     = 32;

    // Position in the frame
    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_CMD  = 3'd1,
        PH_LEN  = 3'd2,
        PH_DATA = 3'd3,
        PH_CRCL = 3'd4,
        PH_CRCH = 3'd5
    } phase_t;

    // Sequencer state
    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_CRC   = 2'd1,
        S_FETCH = 2'd2,
        S_SEND  = 2'd3
    } seq_state_t;

    // Result kinds carried on tuser
    typedef enum logic [1:0] {
        ST_DATA    = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_CRC_ERR = 2'd2,
        ST_LEN_ERR = 2'd3
    } status_t;

    // Control from the sequencer to the CRC unit
    typedef struct packed {
        logic start;      // begin an eight-step update with data_byte
        logic from_init;  // seed the update with CRC_INIT instead of the running value
    } crc_ctl_t;

endpackage

// ===== rtl/core/cfpr_crc_unit.sv =====
// Bit-serial CRC16-Modbus unit: one polynomial step per clock, eight per byte.
// Depends on cfpr_pkg for the polynomial, seed and control struct.
module cfpr_crc_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  cfpr_pkg::crc_ctl_t  ctl,
    input  logic [7:0]          data_byte,
    output logic [15:0]         crc_value,
    output logic                busy
);
    import cfpr_pkg::*;

    logic [15:0]          crc_reg, crc_next;
    logic [CRC_CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]          seed;

    // Load on start, otherwise shift one bit while steps remain
    always_comb
    begin
        seed     = ctl.from_init ? CRC_INIT : crc_reg;
        crc_next = crc_reg;
        cnt_next = cnt_reg;
        if (ctl.start)
        begin
            crc_next = seed ^ {8'h00, data_byte};
            cnt_next = CRC_CNT_W'(CRC_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            crc_next = crc_reg[0] ? ((crc_reg >> 1) ^ CRC_POLY) : (crc_reg >> 1);
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT;
            cnt_reg <= '0;
        end
        else
        begin
            crc_reg <= crc_next;
            cnt_reg <= cnt_next;
        end
    end

    assign crc_value = crc_reg;
    assign busy      = (cnt_reg != '0);

endmodule

// ===== rtl/core/cfpr_ram.sv =====
// Payload store: one write port, one read port with registered read data.
// Depends on cfpr_pkg for depth and address width.
module cfpr_ram (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [cfpr_pkg::ADDR_W-1:0] wr_addr,
    input  logic [7:0]                wr_data,
    input  logic [cfpr_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]                rd_data
);
    import cfpr_pkg::*;

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rd_data_reg;

    // Write payload bytes
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/crc_framed_packet_receiver.sv =====
// Framed packet receiver: byte-wise deframer with CRC16-Modbus check.
// Depends on cfpr_pkg, cfpr_crc_unit and cfpr_ram.
//
// Takes one received byte per input item, hunts for 0xAA, then reads a command
// (0x55 aborts), a length, the payload and a low-byte-first CRC16-Modbus over
// command, length and payload. Start, abort and CRC low bytes are handled in the
// idle state alone. Command, in-range length and payload bytes wait on the
// bit-serial CRC unit: a load, eight polynomial steps and a release of the
// sequencer. An oversized length byte, and a CRC high byte that ends in an error
// or an empty frame, pass through the send state once. The CRC high byte of a good
// frame runs a fetch and a send state per result item, because each payload byte is
// fetched from the payload store with a registered read. Output stalls hold S_SEND.
// A CRC mismatch or a length above 64 emits one error item. tready is low while a
// byte is processed or results are emitted; the last result item may still wait
// in the output register while the next byte is taken.
module crc_framed_packet_receiver (
    input  logic        clk,
    input  logic        rst_n,
    // input item
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // result item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [cfpr_pkg::TDATA_W-1:0] m_axis_tdata, // [7:0] command, [14:8] frame_len,
                                        // [20:15] byte_index, [28:21] data_byte,
                                        // [31:29] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast    // last
);
    import cfpr_pkg::*;

    // Sequencer and frame state
    seq_state_t        state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [7:0]        cmd_reg, cmd_next;
    logic [LEN_W-1:0]  payload_len_reg, payload_len_next;
    logic [LEN_W-1:0]  bytes_rcvd_reg, bytes_rcvd_next;
    logic [7:0]        crc_low_reg, crc_low_next;
    status_t           kind_reg, kind_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;

    // Output register
    logic              m_valid_reg, m_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [7:0]        out_cmd_reg, out_cmd_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;
    logic [ADDR_W-1:0] out_idx_reg, out_idx_next;
    logic [7:0]        out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;

    // Datapath helpers
    logic              accept;
    logic              out_free;
    crc_ctl_t          crc_ctl;
    logic [15:0]       crc_value;
    logic              crc_busy;
    logic              ram_we;
    logic [7:0]        ram_rd_data;
    logic [LEN_W-1:0]  bytes_inc;
    logic [LEN_W-1:0]  idx_inc;
    logic              idx_is_last;

    cfpr_crc_unit u_crc (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (crc_ctl),
        .data_byte (s_axis_tdata),
        .crc_value (crc_value),
        .busy      (crc_busy)
    );

    cfpr_ram u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (bytes_rcvd_reg[ADDR_W-1:0]),
        .wr_data (s_axis_tdata),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign bytes_inc     = bytes_rcvd_reg + 1'b1;
    assign idx_inc       = {1'b0, idx_reg} + 1'b1;
    assign idx_is_last   = (idx_inc == payload_len_reg);

    // Next state and outputs of the sequencer
    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        cmd_next         = cmd_reg;
        payload_len_next = payload_len_reg;
        bytes_rcvd_next  = bytes_rcvd_reg;
        crc_low_next     = crc_low_reg;
        kind_next        = kind_reg;
        idx_next         = idx_reg;
        crc_ctl          = '0;
        ram_we           = 1'b0;

        // Drop the held result once taken
        m_valid_next     = m_valid_reg && !m_axis_tready;
        out_status_next  = out_status_reg;
        out_cmd_next     = out_cmd_reg;
        out_len_next     = out_len_reg;
        out_idx_next     = out_idx_reg;
        out_data_next    = out_data_reg;
        out_last_next    = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (phase_reg)
                        PH_CMD:
                        begin
                            if (s_axis_tdata == ABORT_CMD)
                            begin
                                phase_next = PH_HUNT;
                            end
                            else
                            begin
                                cmd_next          = s_axis_tdata;
                                crc_ctl.start     = 1'b1;
                                crc_ctl.from_init = 1'b1;
                                phase_next        = PH_LEN;
                                state_next        = S_CRC;
                            end
                        end
                        PH_LEN:
                        begin
                            if (s_axis_tdata > 8'(MAX_PAYLOAD))
                            begin
                                // Oversized length: report and resume hunting
                                payload_len_next = LEN_W'(MAX_PAYLOAD);
                                kind_next        = ST_LEN_ERR;
                                phase_next       = PH_HUNT;
                                state_next       = S_SEND;
                            end
                            else
                            begin
                                crc_ctl.start    = 1'b1;
                                payload_len_next = s_axis_tdata[LEN_W-1:0];
                                bytes_rcvd_next  = '0;
                                phase_next       = (s_axis_tdata == 8'h00) ? PH_CRCL : PH_DATA;
                                state_next       = S_CRC;
                            end
                        end
                        PH_DATA:
                        begin
                            ram_we          = 1'b1;
                            crc_ctl.start   = 1'b1;
                            bytes_rcvd_next = bytes_inc;
                            if (bytes_inc >= payload_len_reg)
                            begin
                                phase_next = PH_CRCL;
                            end
                            state_next = S_CRC;
                        end
                        PH_CRCL:
                        begin
                            crc_low_next = s_axis_tdata;
                            phase_next   = PH_CRCH;
                        end
                        PH_CRCH:
                        begin
                            // Check the frame and pick its result
                            phase_next = PH_HUNT;
                            idx_next   = '0;
                            if ({s_axis_tdata, crc_low_reg} != crc_value)
                            begin
                                kind_next  = ST_CRC_ERR;
                                state_next = S_SEND;
                            end
                            else if (payload_len_reg == '0)
                            begin
                                kind_next  = ST_EMPTY;
                                state_next = S_SEND;
                            end
                            else
                            begin
                                kind_next  = ST_DATA;
                                state_next = S_FETCH;
                            end
                        end
                        default:
                        begin
                            // Hunt for the start byte; unused codes land here too
                            if (s_axis_tdata == START_BYTE)
                            begin
                                bytes_rcvd_next = '0;
                                phase_next      = PH_CMD;
                            end
                            else
                            begin
                                phase_next = PH_HUNT;
                            end
                        end
                    endcase
                end
            end
            S_CRC:
            begin
                if (!crc_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FETCH:
            begin
                // Payload byte read in flight
                state_next = S_SEND;
            end
            S_SEND:
            begin
                if (out_free)
                begin
                    m_valid_next    = 1'b1;
                    out_status_next = kind_reg;
                    out_cmd_next    = cmd_reg;
                    out_len_next    = payload_len_reg;
                    if (kind_reg == ST_DATA)
                    begin
                        out_idx_next  = idx_reg;
                        out_data_next = ram_rd_data;
                        out_last_next = idx_is_last;
                        if (idx_is_last)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            idx_next   = idx_inc[ADDR_W-1:0];
                            state_next = S_FETCH;
                        end
                    end
                    else
                    begin
                        out_idx_next  = '0;
                        out_data_next = 8'h00;
                        out_last_next = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            phase_reg       <= PH_HUNT;
            cmd_reg         <= '0;
            payload_len_reg <= '0;
            bytes_rcvd_reg  <= '0;
            crc_low_reg     <= '0;
            kind_reg        <= ST_DATA;
            idx_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            cmd_reg         <= cmd_next;
            payload_len_reg <= payload_len_next;
            bytes_rcvd_reg  <= bytes_rcvd_next;
            crc_low_reg     <= crc_low_next;
            kind_reg        <= kind_next;
            idx_reg         <= idx_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Output payload registers
    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_cmd_reg    <= out_cmd_next;
        out_len_reg    <= out_len_next;
        out_idx_reg    <= out_idx_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, out_data_reg, out_idx_reg, out_len_reg, out_cmd_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // CRC unit only runs while the sequencer waits on it
    a_crc_in_crc_state: assert property (@(posedge clk) disable iff (!rst_n)
        crc_busy |-> (state_reg == S_CRC))
        else $error("CRC unit busy outside S_CRC");

    // Payload count stays below the length while collecting data
    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (bytes_rcvd_reg < payload_len_reg))
        else $error("payload count reached length in data phase");

    // Streaming index stays inside the frame
    a_idx_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SEND || state_reg == S_FETCH) && (kind_reg == ST_DATA))
        |-> ({1'b0, idx_reg} < payload_len_reg))
        else $error("payload index beyond frame length");

    // Single-item results always close the burst
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (out_status_reg != ST_DATA)) |-> out_last_reg)
        else $error("non-payload result without last");

    // No new byte accepted while a frame's results are pending
    a_no_accept_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |=> !accept)
        else $error("byte accepted during result emission");
`endif

endmodule
